>>> sv/ocpu_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the orbit camera pose update.
`timescale 1ns / 1ps
package ocpu_pkg;

    // CORDIC configuration
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < ATAN_ENTRIES) ?
                                       CORDIC_ITERATIONS : ATAN_ENTRIES;
    localparam int CORDIC_CNT_W      = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    // Q2.30 working width
    localparam int ANG_W = 34;
    localparam logic signed [ANG_W-1:0] CORDIC_GAIN    = 34'sd652032874;
    localparam logic signed [ANG_W-1:0] EIGHTH_DEG_Q30 = 34'sd2342541;

    // angle limits, in quarter degrees of the full angle
    localparam logic signed [11:0] HALF_TURN   = 12'sd720;
    localparam logic signed [11:0] FULL_TURN   = 12'sd1440;
    localparam logic signed [11:0] PITCH_LIMIT = 12'sd356;
    localparam logic signed [9:0]  PITCH_RESET = -10'sd120;

    // distance limits, Q15.16
    localparam logic [30:0] DIST_MIN   = 31'd65536;
    localparam logic [30:0] DIST_MAX   = 31'd1310720000;
    localparam logic [30:0] DIST_RESET = 31'd655360;

    // divide-by-ten unit
    localparam int DIV_BITS  = 41;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);

    // shared multiplier schedule
    localparam int STEP_W = 4;
    localparam int MUL_STEPS = 15;
    localparam logic [STEP_W-1:0] STEP_CC_P   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SS_P   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_SC_P   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_CC_Y   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SS_Y   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_SC_Y   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_FX     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_FZ     = 4'd7;
    localparam logic [STEP_W-1:0] STEP_QX     = 4'd8;
    localparam logic [STEP_W-1:0] STEP_QY     = 4'd9;
    localparam logic [STEP_W-1:0] STEP_QZ     = 4'd10;
    localparam logic [STEP_W-1:0] STEP_QW     = 4'd11;
    localparam logic [STEP_W-1:0] STEP_TERM_X = 4'd12;
    localparam logic [STEP_W-1:0] STEP_TERM_Y = 4'd13;
    localparam logic [STEP_W-1:0] STEP_TERM_Z = 4'd14;
    localparam logic [STEP_W-1:0] STEP_LAST   = STEP_TERM_Z;

    // controller to datapath commands
    typedef struct packed {
        logic              capture;
        logic              start;
        logic              mul_calc;
        logic              mul_wr;
        logic [STEP_W-1:0] step;
        logic              out_load;
    } ocpu_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic cordic_busy;
        logic div_busy;
    } ocpu_status_t;

    // arctangent of 2^-i in Q2.30
    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 34'sd843314856;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043836;
            5'd3:    v = 34'sd133525158;
            5'd4:    v = 34'sd67021686;
            5'd5:    v = 34'sd33543515;
            5'd6:    v = 34'sd16775850;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194282;
            5'd9:    v = 34'sd2097149;
            5'd10:   v = 34'sd1048575;
            5'd11:   v = 34'sd524287;
            5'd12:   v = 34'sd262143;
            5'd13:   v = 34'sd131071;
            5'd14:   v = 34'sd65535;
            5'd15:   v = 34'sd32767;
            5'd16:   v = 34'sd16383;
            5'd17:   v = 34'sd8191;
            5'd18:   v = 34'sd4095;
            5'd19:   v = 34'sd2047;
            5'd20:   v = 34'sd1023;
            5'd21:   v = 34'sd511;
            5'd22:   v = 34'sd255;
            5'd23:   v = 34'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/orbit_camera_pose_update.sv
// Orbit camera pose update: top level with APB target registers, controller and datapath.
`timescale 1ns / 1ps
// Each item (drag or zoom) updates the yaw, pitch or distance state and yields one item
// with the camera position and orientation quaternion. Items are processed one at a
// time: an item is set up, then 16 CORDIC iterations run with yaw and pitch in parallel
// lanes, then 15 products pass through one shared 32x32 multiplier; for a zoom the
// divide by ten runs beside the CORDIC and adds nothing. A finished item sits in an
// output register, so the next item is taken while it waits.
// Target registers sit at byte addresses 0, 4 and 8; write them only while idle.
module orbit_camera_pose_update (
    input  logic               aclk,
    input  logic               aresetn,
    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic signed [10:0] s_x_offset,
    input  logic signed [10:0] s_y_offset,
    // result items
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [32:0] m_pos_x,
    output logic signed [32:0] m_pos_y,
    output logic signed [32:0] m_pos_z,
    output logic signed [15:0] m_quat_x,
    output logic signed [15:0] m_quat_y,
    output logic signed [15:0] m_quat_z,
    output logic signed [15:0] m_quat_w,
    output logic [30:0]        m_orbit_distance,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ocpu_pkg::*;

    localparam logic [1:0] REG_TARGET_X = 2'd0;
    localparam logic [1:0] REG_TARGET_Y = 2'd1;
    localparam logic [1:0] REG_TARGET_Z = 2'd2;

    logic [31:0]  target_x_reg, target_y_reg, target_z_reg;
    logic         wr_en;
    logic [1:0]   reg_idx;
    ocpu_cmd_t    cmd;
    ocpu_status_t status;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // target register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_x_reg <= '0;
            target_y_reg <= '0;
            target_z_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TARGET_X: target_x_reg <= pwdata;
                REG_TARGET_Y: target_y_reg <= pwdata;
                REG_TARGET_Z: target_z_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        unique case (reg_idx)
            REG_TARGET_X: prdata = target_x_reg;
            REG_TARGET_Y: prdata = target_y_reg;
            REG_TARGET_Z: prdata = target_z_reg;
            default:      prdata = '0;
        endcase
    end

    ocpu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ocpu_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_command        (s_command),
        .s_x_offset       (s_x_offset),
        .s_y_offset       (s_y_offset),
        .target_x         (target_x_reg),
        .target_y         (target_y_reg),
        .target_z         (target_z_reg),
        .m_pos_x          (m_pos_x),
        .m_pos_y          (m_pos_y),
        .m_pos_z          (m_pos_z),
        .m_quat_x         (m_quat_x),
        .m_quat_y         (m_quat_y),
        .m_quat_z         (m_quat_z),
        .m_quat_w         (m_quat_w),
        .m_orbit_distance (m_orbit_distance)
    );

endmodule

>>> sv/ocpu_cordic.sv
// Two-lane iterative rotation CORDIC giving sine and cosine of the half yaw and half pitch.
`timescale 1ns / 1ps
module ocpu_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [10:0]        yaw,
    input  logic signed [9:0]  pitch,
    output logic               busy,
    output logic signed [31:0] cos_yaw,
    output logic signed [31:0] sin_yaw,
    output logic signed [31:0] cos_pitch,
    output logic signed [31:0] sin_pitch
);
    import ocpu_pkg::*;

    localparam int LANES = 2;

    logic signed [ANG_W-1:0]    x_reg [LANES];
    logic signed [ANG_W-1:0]    y_reg [LANES];
    logic signed [ANG_W-1:0]    z_reg [LANES];
    logic                       flip_reg [LANES];
    logic signed [11:0]         ang [LANES];
    logic signed [11:0]         ang_adj [LANES];
    logic                       flip_in [LANES];
    logic signed [ANG_W-1:0]    atan_val;
    logic [CORDIC_CNT_W-1:0]    cnt_reg;
    logic                       busy_reg;

    // fold half angles beyond ninety degrees back, remember to negate
    always_comb begin
        ang[0] = $signed({1'b0, yaw});
        ang[1] = 12'(pitch);
        for (int l = 0; l < LANES; l++) begin
            if (ang[l] > HALF_TURN) begin
                ang_adj[l] = ang[l] - FULL_TURN;
                flip_in[l] = 1'b1;
            end else if (ang[l] < -HALF_TURN) begin
                ang_adj[l] = ang[l] + FULL_TURN;
                flip_in[l] = 1'b1;
            end else begin
                ang_adj[l] = ang[l];
                flip_in[l] = 1'b0;
            end
        end
    end

    assign atan_val = atan_q30(5'(cnt_reg));

    // iteration counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == CORDIC_CNT_W'(CORDIC_STEPS - 1)) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // one micro-rotation per cycle in each lane
    always_ff @(posedge aclk) begin
        for (int l = 0; l < LANES; l++) begin
            if (start) begin
                x_reg[l]    <= CORDIC_GAIN;
                y_reg[l]    <= '0;
                z_reg[l]    <= ANG_W'(ang_adj[l]) * EIGHTH_DEG_Q30;
                flip_reg[l] <= flip_in[l];
            end else if (busy_reg) begin
                if (!z_reg[l][ANG_W-1]) begin
                    x_reg[l] <= x_reg[l] - (y_reg[l] >>> cnt_reg);
                    y_reg[l] <= y_reg[l] + (x_reg[l] >>> cnt_reg);
                    z_reg[l] <= z_reg[l] - atan_val;
                end else begin
                    x_reg[l] <= x_reg[l] + (y_reg[l] >>> cnt_reg);
                    y_reg[l] <= y_reg[l] - (x_reg[l] >>> cnt_reg);
                    z_reg[l] <= z_reg[l] + atan_val;
                end
            end
        end
    end

    // results, negated for folded angles
    always_comb begin
        cos_yaw   = flip_reg[0] ? 32'(-x_reg[0]) : 32'(x_reg[0]);
        sin_yaw   = flip_reg[0] ? 32'(-y_reg[0]) : 32'(y_reg[0]);
        cos_pitch = flip_reg[1] ? 32'(-x_reg[1]) : 32'(x_reg[1]);
        sin_pitch = flip_reg[1] ? 32'(-y_reg[1]) : 32'(y_reg[1]);
    end

    assign busy = busy_reg;

endmodule

>>> sv/ocpu_div10.sv
// Divide by ten through a shift-and-add reciprocal and a short correction, clamped to the distance range.
`timescale 1ns / 1ps
module ocpu_div10 (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ocpu_pkg::DIV_BITS-1:0] dividend,
    output logic                          busy,
    output logic                          done,
    output logic [30:0]                   quotient
);
    import ocpu_pkg::*;

    // phases: four series terms of 0.8, scale by 1/8, remainder, correction
    localparam logic [2:0] PH_Q4    = 3'd0;
    localparam logic [2:0] PH_Q8    = 3'd1;
    localparam logic [2:0] PH_Q16   = 3'd2;
    localparam logic [2:0] PH_Q32   = 3'd3;
    localparam logic [2:0] PH_SCALE = 3'd4;
    localparam logic [2:0] PH_REM   = 3'd5;
    localparam logic [2:0] PH_FIX   = 3'd6;

    localparam logic [DIV_BITS-1:0] DIVISOR = DIV_BITS'(10);

    logic [DIV_BITS-1:0] dvd_reg;
    logic [DIV_BITS-1:0] q_reg;
    logic [DIV_BITS-1:0] rem_reg;
    logic [2:0]          ph_reg;
    logic                busy_reg;
    logic                done_reg;

    // phase sequencer, done pulses once the remainder is below ten
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= PH_Q4;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                ph_reg   <= PH_Q4;
            end else if (busy_reg) begin
                if (ph_reg == PH_FIX) begin
                    if (rem_reg < DIVISOR) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end else begin
                    ph_reg <= ph_reg + 3'd1;
                end
            end
        end
    end

    // quotient estimate never exceeds the true one; at most a few corrections follow
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            q_reg   <= (dividend >> 1) + (dividend >> 2);
        end else if (busy_reg) begin
            unique case (ph_reg)
                PH_Q4:    q_reg <= q_reg + (q_reg >> 4);
                PH_Q8:    q_reg <= q_reg + (q_reg >> 8);
                PH_Q16:   q_reg <= q_reg + (q_reg >> 16);
                PH_Q32:   q_reg <= q_reg + (q_reg >> 32);
                PH_SCALE: q_reg <= q_reg >> 3;
                PH_REM:   rem_reg <= dvd_reg - ((q_reg << 3) + (q_reg << 1));
                PH_FIX: begin
                    if (rem_reg >= DIVISOR) begin
                        q_reg   <= q_reg + DIV_BITS'(1);
                        rem_reg <= rem_reg - DIVISOR;
                    end
                end
                default: ;
            endcase
        end
    end

    // clamp to the distance range
    always_comb begin
        if (q_reg < DIV_BITS'(DIST_MIN)) begin
            quotient = DIST_MIN;
        end else if (q_reg > DIV_BITS'(DIST_MAX)) begin
            quotient = DIST_MAX;
        end else begin
            quotient = q_reg[30:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

>>> sv/ocpu_datapath.sv
// Datapath: pose state, CORDIC, divider, shared multiplier and the result register.
`timescale 1ns / 1ps
module ocpu_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ocpu_pkg::ocpu_cmd_t    cmd,
    output ocpu_pkg::ocpu_status_t status,
    input  logic                   s_command,
    input  logic signed [10:0]     s_x_offset,
    input  logic signed [10:0]     s_y_offset,
    input  logic [31:0]            target_x,
    input  logic [31:0]            target_y,
    input  logic [31:0]            target_z,
    output logic signed [32:0]     m_pos_x,
    output logic signed [32:0]     m_pos_y,
    output logic signed [32:0]     m_pos_z,
    output logic signed [15:0]     m_quat_x,
    output logic signed [15:0]     m_quat_y,
    output logic signed [15:0]     m_quat_z,
    output logic signed [15:0]     m_quat_w,
    output logic [30:0]            m_orbit_distance
);
    import ocpu_pkg::*;

    // pose state
    logic [10:0]             yaw_reg;
    logic signed [9:0]       pitch_reg;
    logic [30:0]             dist_reg;
    logic                    zoom_reg;
    logic signed [43:0]      n_reg;

    logic signed [12:0]      yaw_sum;
    logic signed [12:0]      yaw_wrap;
    logic signed [11:0]      pitch_sum;
    logic signed [11:0]      pitch_clamp;
    logic signed [11:0]      zoom_factor;

    logic                    div_start;
    logic                    div_busy;
    logic                    div_done;
    logic [30:0]             div_quot;
    logic [DIV_BITS-1:0]     div_dividend;

    logic                    cordic_busy;
    logic signed [31:0]      cy, sy, cp, sp;

    logic signed [ANG_W-1:0] mul_res_reg [MUL_STEPS];
    logic signed [63:0]      prod_reg;
    logic signed [63:0]      prod_rnd;
    logic signed [31:0]      op_a, op_b;
    logic signed [ANG_W-1:0] cos_p, sin_p, cos_y, sin_y;
    logic signed [32:0]      tx, ty, tz;

    // Q2.30 to Q1.15 with rounding and saturation
    function automatic logic signed [15:0] to_q15(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W:0] r;
        r = ($signed({v[ANG_W-1], v}) + $signed((ANG_W+1)'(16384))) >>> 15;
        if (r > 32767) begin
            return 16'sh7fff;
        end else if (r < -32768) begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

    // drag: wrap yaw, clamp pitch; zoom: factor of ten minus the y offset
    always_comb begin
        yaw_sum = $signed({2'b00, yaw_reg}) - 13'(s_x_offset);
        if (yaw_sum < 0) begin
            yaw_wrap = yaw_sum + 13'(FULL_TURN);
        end else if (yaw_sum >= 13'(FULL_TURN)) begin
            yaw_wrap = yaw_sum - 13'(FULL_TURN);
        end else begin
            yaw_wrap = yaw_sum;
        end
        pitch_sum = 12'(pitch_reg) + 12'(s_y_offset);
        if (pitch_sum > PITCH_LIMIT) begin
            pitch_clamp = PITCH_LIMIT;
        end else if (pitch_sum < -PITCH_LIMIT) begin
            pitch_clamp = -PITCH_LIMIT;
        end else begin
            pitch_clamp = pitch_sum;
        end
        zoom_factor = 12'sd10 - 12'(s_y_offset);
    end

    // state update on capture, on a zoom start and at the end of a zoom division
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_reg   <= '0;
            pitch_reg <= PITCH_RESET;
            dist_reg  <= DIST_RESET;
            zoom_reg  <= 1'b0;
        end else begin
            if (cmd.capture) begin
                zoom_reg <= s_command;
                if (!s_command) begin
                    yaw_reg   <= yaw_wrap[10:0];
                    pitch_reg <= pitch_clamp[9:0];
                end
            end
            if (cmd.start && zoom_reg && (n_reg <= 0)) begin
                dist_reg <= DIST_MIN;
            end else if (div_done) begin
                dist_reg <= div_quot;
            end
        end
    end

    // scaled distance numerator
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            n_reg <= $signed({1'b0, dist_reg}) * zoom_factor;
        end
    end

    assign div_start    = cmd.start && zoom_reg && (n_reg > 0);
    assign div_dividend = n_reg[DIV_BITS-1:0] + DIV_BITS'(5);

    ocpu_div10 u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    ocpu_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.start),
        .yaw       (yaw_reg),
        .pitch     (pitch_reg),
        .busy      (cordic_busy),
        .cos_yaw   (cy),
        .sin_yaw   (sy),
        .cos_pitch (cp),
        .sin_pitch (sp)
    );

    assign status.cordic_busy = cordic_busy;
    assign status.div_busy    = div_busy;

    // double-angle terms
    always_comb begin
        cos_p = mul_res_reg[STEP_CC_P] - mul_res_reg[STEP_SS_P];
        sin_p = mul_res_reg[STEP_SC_P] <<< 1;
        cos_y = mul_res_reg[STEP_CC_Y] - mul_res_reg[STEP_SS_Y];
        sin_y = mul_res_reg[STEP_SC_Y] <<< 1;
    end

    // operand select for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (cmd.step)
            STEP_CC_P:   begin op_a = cp;          op_b = cp;          end
            STEP_SS_P:   begin op_a = sp;          op_b = sp;          end
            STEP_SC_P:   begin op_a = sp;          op_b = cp;          end
            STEP_CC_Y:   begin op_a = cy;          op_b = cy;          end
            STEP_SS_Y:   begin op_a = sy;          op_b = sy;          end
            STEP_SC_Y:   begin op_a = sy;          op_b = cy;          end
            STEP_FX:     begin op_a = 32'(cos_p);  op_b = 32'(sin_y);  end
            STEP_FZ:     begin op_a = 32'(cos_p);  op_b = 32'(cos_y);  end
            STEP_QX:     begin op_a = cy;          op_b = sp;          end
            STEP_QY:     begin op_a = sy;          op_b = cp;          end
            STEP_QZ:     begin op_a = sy;          op_b = sp;          end
            STEP_QW:     begin op_a = cy;          op_b = cp;          end
            STEP_TERM_X: begin
                op_a = $signed({1'b0, dist_reg});
                op_b = 32'(mul_res_reg[STEP_FX]);
            end
            STEP_TERM_Y: begin
                op_a = $signed({1'b0, dist_reg});
                op_b = 32'(sin_p);
            end
            STEP_TERM_Z: begin
                op_a = $signed({1'b0, dist_reg});
                op_b = 32'(mul_res_reg[STEP_FZ]);
            end
            default: ;
        endcase
    end

    // multiply, then round half up by 30 bits into the step's slot
    assign prod_rnd = prod_reg + 64'sd536870912;

    always_ff @(posedge aclk) begin
        if (cmd.mul_calc) begin
            prod_reg <= op_a * op_b;
        end
        if (cmd.mul_wr) begin
            mul_res_reg[cmd.step] <= prod_rnd[63:30];
        end
    end

    // result register
    assign tx = $signed({target_x[31], target_x});
    assign ty = $signed({target_y[31], target_y});
    assign tz = $signed({target_z[31], target_z});

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_pos_x          <= tx + mul_res_reg[STEP_TERM_X][32:0];
            m_pos_y          <= ty - mul_res_reg[STEP_TERM_Y][32:0];
            m_pos_z          <= tz + mul_res_reg[STEP_TERM_Z][32:0];
            m_quat_x         <= to_q15(mul_res_reg[STEP_QX]);
            m_quat_y         <= to_q15(mul_res_reg[STEP_QY]);
            m_quat_z         <= to_q15(-mul_res_reg[STEP_QZ]);
            m_quat_w         <= to_q15(mul_res_reg[STEP_QW]);
            m_orbit_distance <= dist_reg;
        end
    end

endmodule

>>> sv/ocpu_ctrl.sv
// Controller state machine: item capture, CORDIC and divider wait, multiply schedule, result hand-off.
`timescale 1ns / 1ps
module ocpu_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  ocpu_pkg::ocpu_status_t status,
    output ocpu_pkg::ocpu_cmd_t    cmd
);
    import ocpu_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              phase_reg, phase_next;
    logic              full_reg, full_next;
    logic              out_free;

    assign out_free = !full_reg || m_ready;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START: begin
                cmd.start  = 1'b1;
                state_next = S_RUN;
            end
            S_RUN: begin
                if (!status.cordic_busy && !status.div_busy) begin
                    state_next = S_MUL;
                    step_next  = '0;
                    phase_next = 1'b0;
                end
            end
            S_MUL: begin
                if (!phase_reg) begin
                    cmd.mul_calc = 1'b1;
                    phase_next   = 1'b1;
                end else begin
                    cmd.mul_wr = 1'b1;
                    phase_next = 1'b0;
                    if (step_reg == STEP_LAST) begin
                        state_next = S_OUT;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        // result register occupancy
        if (cmd.out_load) begin
            full_next = 1'b1;
        end else if (m_ready) begin
            full_next = 1'b0;
        end else begin
            full_next = full_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            phase_reg <= 1'b0;
            full_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
            full_reg  <= full_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = full_reg;

endmodule

>>> sv/ocpu_checker.sv
// Port-level checks for the orbit camera pose update, bound to the top level.
`timescale 1ns / 1ps
module ocpu_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [32:0] m_pos_x,
    input logic signed [15:0] m_quat_w,
    input logic [30:0]        m_orbit_distance,
    input logic               pready
);
    import ocpu_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pos_x) && $stable(m_quat_w)
                                && $stable(m_orbit_distance))
        else $error("result item changed while stalled");

    // distance always within the clamp range
    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_orbit_distance >= DIST_MIN) && (m_orbit_distance <= DIST_MAX))
        else $error("orbit distance out of range");

    // one item at a time: input closes right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while busy");

    // configuration port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind orbit_camera_pose_update ocpu_checker u_checker (.*);

>>> bench/tb_orbit_camera_pose_update.sv
// Testbench for the orbit camera pose update: directed table, random events, predicted poses.
`timescale 1ns / 1ps
module tb_orbit_camera_pose_update;
    import ocpu_pkg::*;

    localparam logic CMD_DRAG = 1'b0;
    localparam logic CMD_ZOOM = 1'b1;
    localparam logic [3:0] REG_TARGET_X = 4'd0;
    localparam logic [3:0] REG_TARGET_Y = 4'd4;
    localparam logic [3:0] REG_TARGET_Z = 4'd8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_EVENTS = 950;

    typedef struct packed {
        logic signed [32:0] pos_x;
        logic signed [32:0] pos_y;
        logic signed [32:0] pos_z;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic [30:0]        orbit_dist;
    } pose_t;

    // directed row: event plus a flag for a hand-typed distance check
    typedef struct {
        logic        cmd;
        int          xo;
        int          yo;
        bit          typed;
        pose_t       pose;
    } event_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_command;
    logic signed [10:0] s_x_offset;
    logic signed [10:0] s_y_offset;
    logic               m_valid;
    logic               m_ready;
    logic signed [32:0] m_pos_x;
    logic signed [32:0] m_pos_y;
    logic signed [32:0] m_pos_z;
    logic signed [15:0] m_quat_x;
    logic signed [15:0] m_quat_y;
    logic signed [15:0] m_quat_z;
    logic signed [15:0] m_quat_w;
    logic [30:0]        m_orbit_distance;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    orbit_camera_pose_update dut (.*);

    // camera state mirror
    logic [31:0]   tgt_x, tgt_y, tgt_z;
    int            yaw_q;
    int            pitch_q;
    longint        dist_q16;

    pose_t         pending_poses[$];
    logic [30:0]   typed_dist;
    bit            have_typed;
    int            cycle_count = 0;
    int            errors;
    bit            no_idle;
    bit            hold_off;

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return fshift(a * b + (64'sd1 << 29), 30);
    endfunction

    function automatic longint arctan_q30(int i);
        longint tab[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
            33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
            262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
            255, 127};
        return tab[i];
    endfunction

    // rotation CORDIC on a half angle given in eighths of a degree
    task automatic half_sincos(input longint eighths, output longint c, output longint s);
        bit     flip;
        longint x, y, z, dx, dy;
        int     steps;
        flip = 0;
        x = 652032874;
        y = 0;
        steps = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;
        if (eighths > 720) begin
            eighths -= 1440;
            flip = 1;
        end else if (eighths < -720) begin
            eighths += 1440;
            flip = 1;
        end
        z = eighths * 2342541;
        for (int i = 0; i < steps; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_q30(i);
            end else begin
                x += dx; y -= dy; z += arctan_q30(i);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endtask

    function automatic logic signed [15:0] quat_part(longint v);
        longint r;
        r = fshift(v + (64'sd1 << 14), 15);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic logic signed [32:0] place(logic [31:0] tgt, longint d, longint f,
                                                 bit add);
        longint term, t;
        term = q30_mul(d, f);
        t = longint'(signed'(tgt));
        return add ? 33'(t + term) : 33'(t - term);
    endfunction

    // advance the camera state by one event and return the resulting pose
    task automatic advance_pose(input logic cmd, input int xo, input int yo, output pose_t p);
        longint cy, sy, cp, sp, cosp, sinp, cosy, siny, n, d, t, q;
        if (cmd == CMD_DRAG) begin
            t = yaw_q - xo;
            q = pitch_q + yo;
            while (t < 0) t += 1440;
            while (t >= 1440) t -= 1440;
            if (q > 356) q = 356;
            if (q < -356) q = -356;
            yaw_q = int'(t);
            pitch_q = int'(q);
        end else begin
            n = dist_q16 * (10 - yo);
            if (n <= 0) d = 65536;
            else begin
                d = (n + 5) / 10;
                if (d < 65536) d = 65536;
                if (d > 1310720000) d = 1310720000;
            end
            dist_q16 = d;
        end
        half_sincos(yaw_q, cy, sy);
        half_sincos(pitch_q, cp, sp);
        cosp = q30_mul(cp, cp) - q30_mul(sp, sp);
        sinp = 2 * q30_mul(sp, cp);
        cosy = q30_mul(cy, cy) - q30_mul(sy, sy);
        siny = 2 * q30_mul(sy, cy);
        p.pos_x = place(tgt_x, dist_q16, q30_mul(cosp, siny), 1);
        p.pos_y = place(tgt_y, dist_q16, sinp, 0);
        p.pos_z = place(tgt_z, dist_q16, q30_mul(cosp, cosy), 1);
        p.quat_x = quat_part(q30_mul(cy, sp));
        p.quat_y = quat_part(q30_mul(sy, cp));
        p.quat_z = quat_part(-q30_mul(sy, sp));
        p.quat_w = quat_part(q30_mul(cy, cp));
        p.orbit_dist = dist_q16[30:0];
    endtask

    // configuration write: setup then access; the caller closes the transfer
    task automatic write_reg(input logic [3:0] addr, input logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (addr)
            REG_TARGET_X: tgt_x = value;
            REG_TARGET_Y: tgt_y = value;
            REG_TARGET_Z: tgt_z = value;
            default: ;
        endcase
    endtask

    task automatic set_targets(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z);
        write_reg(REG_TARGET_X, x);
        write_reg(REG_TARGET_Y, y);
        write_reg(REG_TARGET_Z, z);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // offer one item, predict it, wait for acceptance; valid stays up for the next item
    task automatic send_event(input logic cmd, input int xo, input int yo);
        pose_t p;
        bit    idle;
        idle = !no_idle && ($urandom_range(99) < 12);
        if (idle) s_valid <= 1'b0;
        while (idle) begin
            @(posedge aclk);
            idle = !no_idle && ($urandom_range(99) < 12);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_x_offset <= 11'(xo);
        s_y_offset <= 11'(yo);
        advance_pose(cmd, xo, yo, p);
        pending_poses.push_back(p);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending_poses.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic cmp(input string name, input longint e, input longint a);
        if (e != a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            errors++;
        end
    endtask

    // result checking
    always @(posedge aclk) begin
        pose_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_poses.size() == 0) begin
                $error("result item with no pose waiting");
                errors++;
            end else begin
                e = pending_poses.pop_front();
                if (have_typed) begin
                    cmp("orbit_distance", typed_dist, m_orbit_distance);
                    have_typed = 0;
                end
                cmp("pos_x", e.pos_x, m_pos_x);
                cmp("pos_y", e.pos_y, m_pos_y);
                cmp("pos_z", e.pos_z, m_pos_z);
                cmp("quat_x", e.quat_x, m_quat_x);
                cmp("quat_y", e.quat_y, m_quat_y);
                cmp("quat_z", e.quat_z, m_quat_z);
                cmp("quat_w", e.quat_w, m_quat_w);
                cmp("orbit_distance", e.orbit_dist, m_orbit_distance);
            end
        end
    end

    // receiver stalls, plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !hold_off && (no_idle || $urandom_range(99) >= 12);
    end

    initial begin
        hold_off = 0;
        wait (cycle_count == 3000);
        hold_off = 1;
        repeat (300) @(posedge aclk);
        hold_off = 0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_orbit_camera_pose_update: FAIL");
            $finish;
        end
    end

    event_row_t rows[$];

    initial begin
        event_row_t r;
        int         kind;
        errors = 0; no_idle = 0; have_typed = 0; typed_dist = '0;
        aresetn = 1'b0; s_valid = 1'b0; s_command = CMD_DRAG;
        s_x_offset = '0; s_y_offset = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        tgt_x = 0; tgt_y = 0; tgt_z = 0;
        yaw_q = 0; pitch_q = -120; dist_q16 = 655360;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; a zero drag after reset leaves distance at 10.0
        r = '{CMD_DRAG, 0, 0, 0, '0};          rows.push_back(r);
        r = '{CMD_DRAG, -1024, 1023, 0, '0};   rows.push_back(r);   // pitch clamps high
        r = '{CMD_DRAG, 1023, -1024, 0, '0};   rows.push_back(r);   // pitch clamps low
        r = '{CMD_DRAG, 1, 0, 0, '0};          rows.push_back(r);   // yaw down to 0
        r = '{CMD_DRAG, -1, 0, 0, '0};         rows.push_back(r);   // and back
        r = '{CMD_DRAG, -720, 356, 0, '0};     rows.push_back(r);   // half yaw just over 90
        r = '{CMD_DRAG, -4, 0, 0, '0};         rows.push_back(r);   // beyond 90
        r = '{CMD_DRAG, -715, -356, 0, '0};    rows.push_back(r);
        r = '{CMD_ZOOM, 0, 1023, 0, '0};       rows.push_back(r);   // factor negative
        r = '{CMD_ZOOM, 0, 10, 0, '0};         rows.push_back(r);   // factor zero
        r = '{CMD_ZOOM, 1023, -1024, 0, '0};   rows.push_back(r);   // grow
        r = '{CMD_ZOOM, -1024, -1024, 0, '0};  rows.push_back(r);
        r = '{CMD_ZOOM, 0, -1024, 0, '0};      rows.push_back(r);   // clamps at max
        r = '{CMD_ZOOM, 0, 1, 0, '0};          rows.push_back(r);
        r = '{CMD_ZOOM, 0, 9, 0, '0};          rows.push_back(r);
        r = '{CMD_DRAG, 0, 356, 0, '0};        rows.push_back(r);   // pitch back to zero
        r = '{CMD_DRAG, -720, 0, 0, '0};       rows.push_back(r);
        foreach (rows[i]) begin
            if (i == 9) begin
                // zoom factor zero lands on minimum distance, readable at a glance
                rows[i].typed = 1;
            end
        end
        foreach (rows[i]) begin
            if (rows[i].typed) begin
                // only the distance is hand-typed; the rest is checked against the prediction
                drain();
                have_typed = 0;
            end
            send_event(rows[i].cmd, rows[i].xo, rows[i].yo);
            if (rows[i].typed) begin
                typed_dist = 31'd65536;
                have_typed = 1;
            end
        end
        drain();

        // target settings, extremes included
        set_targets(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        for (int i = 0; i < 6; i++) send_event(i[0], 1023 - i * 400, -1024 + i * 400);
        drain();
        set_targets(32'h80000000, 32'h7fffffff, 32'h80000000);
        for (int i = 0; i < 6; i++) send_event(CMD_ZOOM, 0, (i % 2) ? 1023 : -1024);
        drain();

        // random events across several target settings
        for (int ph = 0; ph < 4; ph++) begin
            set_targets($urandom, $urandom, $urandom);
            no_idle = (ph == 2);
            for (int i = 0; i < RANDOM_EVENTS / 4; i++) begin
                kind = $urandom_range(99);
                if (kind < 60)
                    send_event(CMD_DRAG, $urandom_range(2047) - 1024,
                               $urandom_range(2047) - 1024);
                else if (kind < 70)
                    send_event(CMD_DRAG, $urandom_range(20) - 10, $urandom_range(20) - 10);
                else if (kind < 90)
                    send_event(CMD_ZOOM, $urandom_range(2047) - 1024,
                               $urandom_range(20) - 10);
                else
                    send_event(CMD_ZOOM, $urandom_range(2047) - 1024,
                               $urandom_range(2047) - 1024);
            end
            drain();
        end
        no_idle = 0;

        if (errors == 0 && pending_poses.size() == 0) begin
            $display("tb_orbit_camera_pose_update: PASS");
        end else begin
            $display("tb_orbit_camera_pose_update: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/ocpu_pkg.sv
sv/ocpu_cordic.sv
sv/ocpu_div10.sv
sv/ocpu_datapath.sv
sv/ocpu_ctrl.sv
sv/orbit_camera_pose_update.sv
sv/ocpu_checker.sv
bench/tb_orbit_camera_pose_update.sv
